>>> design/i2c_master_transaction_sequencer_assert.svh
// assertion macros for the i2c transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/i2cmts_pkg.sv
// shared types and constants for the i2c transaction sequencer
`timescale 1ns / 1ps

package i2cmts_pkg;

  localparam int WRITE_DEPTH_DEF = 64;
  localparam int READ_DEPTH_DEF  = 64;
  localparam int BUF_SLOTS       = 64;
  localparam int BUF_AW          = $clog2(BUF_SLOTS);
  localparam logic [7:0] RW_BIT  = 8'h01;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_EVENT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ADDR      = 3'd1,
    CMD_DATA      = 3'd2,
    CMD_ACK_RECV  = 3'd3,
    CMD_STOP      = 3'd4,
    CMD_NACK_STOP = 3'd5,
    CMD_CLR_ERR   = 3'd6
  } bus_cmd_t;

  typedef enum logic [2:0] {
    RES_BUSY    = 3'd0,
    RES_OK      = 3'd1,
    RES_NACK    = 3'd2,
    RES_ARB     = 3'd3,
    RES_BUS_ERR = 3'd4,
    RES_UNEXP   = 3'd5
  } result_t;

endpackage

>>> design/i2c_master_transaction_sequencer.sv
// an accepted item is held in the input stage, then in the result register
// throughput: one item per cycle unless out_ready stalls; each is decided in one pass
// the write buffer read is prefetched at the next byte pointer, so data sends never stall
// reset: synchronous, active low; clears busy, counters, address and both stage valids
// the write buffer is not cleared; entries read before being loaded are undefined
`timescale 1ns / 1ps
`include "i2c_master_transaction_sequencer_assert.svh"

module i2c_master_transaction_sequencer #(
  parameter int WRITE_DEPTH = i2cmts_pkg::WRITE_DEPTH_DEF,
  parameter int READ_DEPTH  = i2cmts_pkg::READ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_buffer_index,
  input  logic [7:0] in_slave_address,
  input  logic [7:0] in_write_count,
  input  logic [7:0] in_read_count,
  input  logic       in_flag_arb_lost,
  input  logic       in_flag_bus_error,
  input  logic       in_flag_write_done,
  input  logic       in_flag_read_done,
  input  logic       in_flag_nack,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic [2:0] out_bus_cmd,
  output logic [7:0] out_bus_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic [5:0] out_read_position,
  output logic       out_done_res,
  output logic [2:0] out_result_code,
  output logic       out_ready_res
);

  import i2cmts_pkg::*;

  // size limits; writes are also bounded by the buffer
  localparam int WLIM_INT = (WRITE_DEPTH < BUF_SLOTS) ? WRITE_DEPTH : BUF_SLOTS;
  localparam logic [8:0] WLIM   = 9'(WLIM_INT);
  localparam logic [8:0] RLIM   = 9'(READ_DEPTH);
  localparam logic [8:0] WDEPTH = 9'(WRITE_DEPTH);
  localparam logic [7:0] RSF_MAX = 8'hFF;

  // input stage
  logic       stg_valid_r;
  logic [1:0] stg_func_r;
  logic [7:0] stg_data_r;
  logic [5:0] stg_idx_r;
  logic [7:0] stg_addr_r;
  logic [7:0] stg_wcnt_r;
  logic [7:0] stg_rcnt_r;
  logic       stg_arb_r;
  logic       stg_berr_r;
  logic       stg_wdone_r;
  logic       stg_rdone_r;
  logic       stg_nack_r;
  logic       stg_fire;

  // transaction state
  logic       busy_r,  busy_nxt;
  logic [7:0] tgt_r,   tgt_nxt;
  logic [6:0] wtot_r,  wtot_nxt;
  logic [7:0] rtot_r,  rtot_nxt;
  logic [6:0] wsf_r,   wsf_nxt;
  logic [7:0] rsf_r,   rsf_nxt;
  logic [7:0] rsf_inc;

  // result register
  logic       out_valid_r;
  logic       o_acc_r,   o_acc_nxt;
  bus_cmd_t   o_cmd_r,   o_cmd_nxt;
  logic [7:0] o_byte_r,  o_byte_nxt;
  logic       o_rv_r,    o_rv_nxt;
  logic [7:0] o_rbyte_r, o_rbyte_nxt;
  logic [5:0] o_rpos_r,  o_rpos_nxt;
  logic       o_done_r,  o_done_nxt;
  result_t    o_code_r,  o_code_nxt;
  logic       o_rdy_r,   o_rdy_nxt;

  // write buffer
  logic              buf_we;
  logic [7:0]        buf_rdata;

  // stage advances when the result register is free or being drained
  assign stg_fire = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || stg_fire;

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      stg_func_r  <= in_func;
      stg_data_r  <= in_data_byte;
      stg_idx_r   <= in_buffer_index;
      stg_addr_r  <= in_slave_address;
      stg_wcnt_r  <= in_write_count;
      stg_rcnt_r  <= in_read_count;
      stg_arb_r   <= in_flag_arb_lost;
      stg_berr_r  <= in_flag_bus_error;
      stg_wdone_r <= in_flag_write_done;
      stg_rdone_r <= in_flag_read_done;
      stg_nack_r  <= in_flag_nack;
    end
  end

  // buffer write on an accepted load; read is prefetched at the next byte pointer
  i2cmts_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SLOTS)
  ) u_wbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (stg_idx_r[BUF_AW-1:0]),
    .wdata (stg_data_r),
    .raddr (wsf_nxt[BUF_AW-1:0]),
    .rdata (buf_rdata)
  );

  assign rsf_inc = (rsf_r != RSF_MAX) ? rsf_r + 8'd1 : rsf_r;

  // single-pass decision for the item in the input stage
  always_comb begin
    busy_nxt    = busy_r;
    tgt_nxt     = tgt_r;
    wtot_nxt    = wtot_r;
    rtot_nxt    = rtot_r;
    wsf_nxt     = wsf_r;
    rsf_nxt     = rsf_r;
    buf_we      = 1'b0;
    o_acc_nxt   = 1'b0;
    o_cmd_nxt   = CMD_NONE;
    o_byte_nxt  = 8'd0;
    o_rv_nxt    = 1'b0;
    o_rbyte_nxt = 8'd0;
    o_rpos_nxt  = 6'd0;
    o_done_nxt  = 1'b0;
    o_code_nxt  = RES_BUSY;
    if (stg_fire) begin
      case (stg_func_r)
        FN_LOAD: begin
          if (!busy_r && ({3'd0, stg_idx_r} < WDEPTH)) begin
            buf_we    = 1'b1;
            o_acc_nxt = 1'b1;
          end
        end
        FN_START: begin
          if (!busy_r && ({1'b0, stg_wcnt_r} <= WLIM) && ({1'b0, stg_rcnt_r} <= RLIM)) begin
            o_acc_nxt = 1'b1;
            tgt_nxt   = stg_addr_r;
            wtot_nxt  = stg_wcnt_r[6:0];
            rtot_nxt  = stg_rcnt_r;
            wsf_nxt   = 7'd0;
            rsf_nxt   = 8'd0;
            if (stg_wcnt_r != 8'd0) begin
              busy_nxt   = 1'b1;
              o_cmd_nxt  = CMD_ADDR;
              o_byte_nxt = stg_addr_r & ~RW_BIT;
            end else if (stg_rcnt_r != 8'd0) begin
              busy_nxt   = 1'b1;
              o_cmd_nxt  = CMD_ADDR;
              o_byte_nxt = stg_addr_r | RW_BIT;
            end else begin
              // empty transaction ends at once
              o_done_nxt = 1'b1;
              o_code_nxt = RES_OK;
            end
          end
        end
        FN_EVENT: begin
          if (busy_r) begin
            if (stg_arb_r || stg_berr_r) begin
              // bus error wins over arbitration loss
              o_cmd_nxt  = CMD_CLR_ERR;
              o_done_nxt = 1'b1;
              o_code_nxt = stg_berr_r ? RES_BUS_ERR : RES_ARB;
              busy_nxt   = 1'b0;
            end else if (stg_wdone_r) begin
              if (stg_nack_r) begin
                o_cmd_nxt  = CMD_STOP;
                o_done_nxt = 1'b1;
                o_code_nxt = RES_NACK;
                busy_nxt   = 1'b0;
              end else if (wsf_r < wtot_r) begin
                o_cmd_nxt  = CMD_DATA;
                o_byte_nxt = buf_rdata;
                wsf_nxt    = wsf_r + 7'd1;
              end else if (rsf_r < rtot_r) begin
                // repeated start for the read phase
                o_cmd_nxt  = CMD_ADDR;
                o_byte_nxt = tgt_r | RW_BIT;
              end else begin
                o_cmd_nxt  = CMD_STOP;
                o_done_nxt = 1'b1;
                o_code_nxt = RES_OK;
                busy_nxt   = 1'b0;
              end
            end else if (stg_rdone_r) begin
              o_rv_nxt    = 1'b1;
              o_rbyte_nxt = stg_data_r;
              o_rpos_nxt  = rsf_r[5:0];
              rsf_nxt     = rsf_inc;
              if (rsf_inc < rtot_r) begin
                o_cmd_nxt = CMD_ACK_RECV;
              end else begin
                o_cmd_nxt  = CMD_NACK_STOP;
                o_done_nxt = 1'b1;
                o_code_nxt = RES_OK;
                busy_nxt   = 1'b0;
              end
            end else begin
              o_done_nxt = 1'b1;
              o_code_nxt = RES_UNEXP;
              busy_nxt   = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    o_rdy_nxt = !busy_nxt;
  end

  // transaction state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tgt_r  <= 8'd0;
      wtot_r <= 7'd0;
      rtot_r <= 8'd0;
      wsf_r  <= 7'd0;
      rsf_r  <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      tgt_r  <= tgt_nxt;
      wtot_r <= wtot_nxt;
      rtot_r <= rtot_nxt;
      wsf_r  <= wsf_nxt;
      rsf_r  <= rsf_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (stg_fire) begin
      o_acc_r   <= o_acc_nxt;
      o_cmd_r   <= o_cmd_nxt;
      o_byte_r  <= o_byte_nxt;
      o_rv_r    <= o_rv_nxt;
      o_rbyte_r <= o_rbyte_nxt;
      o_rpos_r  <= o_rpos_nxt;
      o_done_r  <= o_done_nxt;
      o_code_r  <= o_code_nxt;
      o_rdy_r   <= o_rdy_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = o_acc_r;
  assign out_bus_cmd       = o_cmd_r;
  assign out_bus_byte      = o_byte_r;
  assign out_read_valid    = o_rv_r;
  assign out_read_byte     = o_rbyte_r;
  assign out_read_position = o_rpos_r;
  assign out_done_res      = o_done_r;
  assign out_result_code   = o_code_r;
  assign out_ready_res     = o_rdy_r;

  // consistency checks
  `SEQ_ASSERT_NOW(a_done_code, out_valid_r && o_done_r,
                  (o_code_r != RES_BUSY) && o_rdy_r, "finished transfer without code or idle")
  `SEQ_ASSERT_NOW(a_busy_code, out_valid_r && !o_done_r,
                  o_code_r == RES_BUSY, "result code set on an unfinished transfer")
  `SEQ_ASSERT_NOW(a_read_cmd, out_valid_r && o_rv_r,
                  (o_cmd_r == CMD_ACK_RECV) || (o_cmd_r == CMD_NACK_STOP),
                  "received byte without a receive command")
  `SEQ_ASSERT_NOW(a_write_ptr, busy_r, wsf_r <= wtot_r, "write pointer past write count")
  `SEQ_ASSERT_NEXT(a_stage_hold, stg_valid_r && !stg_fire, stg_valid_r && $stable(stg_func_r),
                   "stalled input stage lost its item")

endmodule

>>> design/i2cmts_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module i2cmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
